FILE: rtl/core/u8d_pkg.sv
`default_nettype none
package u8d_pkg;

  // Width of a decoded code point
  localparam int CP_WIDTH = 31;

  // Default depth of the result queue (at least two)
  localparam int QUEUE_DEPTH = 4;

  // Value given for a malformed sequence: '?'
  localparam logic [CP_WIDTH-1:0] REPLACEMENT_CHAR = 31'd63;

  // One queued result
  typedef struct packed {
    logic [CP_WIDTH-1:0] code_point;
    logic                replaced;
    logic                last_of_run;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/utf8_stream_decoder.sv
`default_nettype none
// UTF-8 stream decoder, lead bytes up to FC-FF (values up to 31 bits).
// Input channel: byte_valid / byte_ready carry text_byte and end_of_text,
// one byte of text per transaction. Output channel: result_valid /
// result_ready carry code_point, replaced and last_of_run, one decoded
// value per transaction. A byte gives zero, one or two results.
// Decoding of an accepted byte finishes in the cycle it is accepted; its
// results are written into a small result queue (DEPTH entries) at that
// clock edge and are offered from the queue in order, oldest first.
// Throughput is one byte per cycle while each byte gives at most one
// result and the receiver keeps up; a byte that gives two results holds
// the output for both, since the output channel moves one result per cycle.
// byte_ready is high while the queue has room for two results, so a
// stalled receiver lets the queue fill and then holds off the sender; no
// result is lost or repeated. Synchronous reset clears the decode state
// (pending count, partial value, skip mode) and empties the queue; the
// block accepts bytes in the first cycle after reset.
module utf8_stream_decoder #(
  parameter int DEPTH = u8d_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          byte_valid,
  output logic                               byte_ready,
  input  wire logic [7:0]                    text_byte,
  input  wire logic                          end_of_text,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic [u8d_pkg::CP_WIDTH-1:0]       code_point,
  output logic                               replaced,
  output logic                               last_of_run
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Decode state
  logic [2:0]                        bytes_pending;
  logic [u8d_pkg::CP_WIDTH-1:0]      partial_value;
  logic                              skipping;
  logic [2:0]                        bytes_pending_next;
  logic [u8d_pkg::CP_WIDTH-1:0]      partial_value_next;
  logic                              skipping_next;

  // Result queue
  u8d_pkg::result_t                  queue [DEPTH];
  logic [PTR_W-1:0]                  wr_ptr;
  logic [PTR_W-1:0]                  rd_ptr;
  logic [CNT_W-1:0]                  count;
  logic [PTR_W-1:0]                  wr_ptr_next;
  logic [PTR_W-1:0]                  rd_ptr_next;
  logic [CNT_W-1:0]                  count_next;

  // Results of the current byte
  u8d_pkg::result_t                  slot0;
  u8d_pkg::result_t                  slot1;
  logic [1:0]                        push_n;

  logic                              accept;
  logic                              pop;
  logic                              is_cont;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign accept       = byte_valid && byte_ready;
  assign pop          = result_valid && result_ready;
  assign byte_ready   = (count <= CNT_W'(DEPTH - 2));
  assign result_valid = (count != '0);
  assign code_point   = queue[rd_ptr].code_point;
  assign replaced     = queue[rd_ptr].replaced;
  assign last_of_run  = queue[rd_ptr].last_of_run;
  assign is_cont      = (text_byte[7:6] == 2'b10);

  // Decode one byte: end of sequence or interruption, lead, open at end
  always_comb begin
    logic                         a_v;
    logic [u8d_pkg::CP_WIDTH-1:0] a_val;
    logic                         a_repl;
    logic                         b_v;
    logic [u8d_pkg::CP_WIDTH-1:0] b_val;
    logic                         b_repl;
    logic                         c_v;
    logic                         do_lead;
    logic [2:0]                   pend_dec;
    a_v    = 1'b0;
    a_val  = u8d_pkg::REPLACEMENT_CHAR;
    a_repl = 1'b1;
    b_v    = 1'b0;
    b_val  = u8d_pkg::REPLACEMENT_CHAR;
    b_repl = 1'b1;
    c_v    = 1'b0;
    do_lead = 1'b0;
    pend_dec = bytes_pending - 3'd1;
    bytes_pending_next = bytes_pending;
    partial_value_next = partial_value;
    skipping_next      = skipping;

    if (!(skipping && is_cont)) begin
      skipping_next = 1'b0;
      if (bytes_pending != 3'd0) begin
        if (is_cont) begin
          // Shift in six more bits, finish when the count runs out
          partial_value_next = {partial_value[u8d_pkg::CP_WIDTH-7:0], text_byte[5:0]};
          bytes_pending_next = pend_dec;
          if (pend_dec == 3'd0) begin
            a_v    = 1'b1;
            a_val  = partial_value_next;
            a_repl = 1'b0;
            partial_value_next = '0;
          end
        end else begin
          // Interrupted sequence: replace, then treat the byte as a lead
          a_v = 1'b1;
          bytes_pending_next = 3'd0;
          partial_value_next = '0;
          do_lead = 1'b1;
        end
      end else begin
        do_lead = 1'b1;
      end

      if (do_lead) begin
        if (!text_byte[7]) begin
          b_v    = 1'b1;
          b_val  = {{(u8d_pkg::CP_WIDTH-8){1'b0}}, text_byte};
          b_repl = 1'b0;
        end else if (is_cont) begin
          // Stray continuation: replace and skip the rest
          b_v = 1'b1;
          skipping_next = 1'b1;
        end else if (text_byte[7:5] == 3'b110) begin
          partial_value_next = {{(u8d_pkg::CP_WIDTH-5){1'b0}}, text_byte[4:0]};
          bytes_pending_next = 3'd1;
        end else if (text_byte[7:4] == 4'b1110) begin
          partial_value_next = {{(u8d_pkg::CP_WIDTH-4){1'b0}}, text_byte[3:0]};
          bytes_pending_next = 3'd2;
        end else if (text_byte[7:3] == 5'b11110) begin
          partial_value_next = {{(u8d_pkg::CP_WIDTH-3){1'b0}}, text_byte[2:0]};
          bytes_pending_next = 3'd3;
        end else if (text_byte[7:2] == 6'b111110) begin
          partial_value_next = {{(u8d_pkg::CP_WIDTH-2){1'b0}}, text_byte[1:0]};
          bytes_pending_next = 3'd4;
        end else begin
          partial_value_next = {{(u8d_pkg::CP_WIDTH-1){1'b0}}, text_byte[0]};
          bytes_pending_next = 3'd5;
        end
      end

      // Sequence left open at end of text
      c_v = end_of_text && (bytes_pending_next != 3'd0);
    end

    // End of text returns the decode state to its reset values
    if (end_of_text) begin
      bytes_pending_next = 3'd0;
      partial_value_next = '0;
      skipping_next      = 1'b0;
    end

    // Pack the results in order; at most two are ever raised
    push_n = {1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v};
    if (a_v) begin
      slot0 = '{code_point: a_val, replaced: a_repl, last_of_run: 1'b0};
    end else if (b_v) begin
      slot0 = '{code_point: b_val, replaced: b_repl, last_of_run: 1'b0};
    end else begin
      slot0 = '{code_point: u8d_pkg::REPLACEMENT_CHAR, replaced: 1'b1, last_of_run: 1'b0};
    end
    if (a_v && b_v) begin
      slot1 = '{code_point: b_val, replaced: b_repl, last_of_run: 1'b1};
    end else begin
      slot1 = '{code_point: u8d_pkg::REPLACEMENT_CHAR, replaced: 1'b1, last_of_run: 1'b1};
    end
    slot0.last_of_run = (push_n == 2'd1);
  end

  // Advance queue pointers and count
  always_comb begin
    wr_ptr_next = wr_ptr;
    if (accept && (push_n == 2'd1)) begin
      wr_ptr_next = ptr_inc(wr_ptr);
    end else if (accept && (push_n == 2'd2)) begin
      wr_ptr_next = ptr_inc(ptr_inc(wr_ptr));
    end
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    count_next  = count + (accept ? CNT_W'(push_n) : CNT_W'(0)) - CNT_W'(pop);
  end

  // Hold decode state and queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 3'd0;
      partial_value <= '0;
      skipping      <= 1'b0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (accept) begin
        bytes_pending <= bytes_pending_next;
        partial_value <= partial_value_next;
        skipping      <= skipping_next;
      end
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Write the results of an accepted byte into the queue
  always_ff @(posedge clk) begin
    if (accept && (push_n != 2'd0)) begin
      queue[wr_ptr] <= slot0;
    end
    if (accept && (push_n == 2'd2)) begin
      queue[ptr_inc(wr_ptr)] <= slot1;
    end
  end

  // The queue never holds more than its depth
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  // A byte marked end of text leaves the decoder idle
  assert property (@(posedge clk) disable iff (rst)
    accept && end_of_text |=> (bytes_pending == 3'd0) && !skipping)
    else $error("decode state not cleared at end of text");

  // Skip mode only runs with no sequence open
  assert property (@(posedge clk) disable iff (rst) skipping |-> (bytes_pending == 3'd0))
    else $error("skip mode with a sequence open");

endmodule
`default_nettype wire

FILE: bench/utf8_check_pkg.sv
`timescale 1ns / 100ps
package utf8_check_pkg;
  import u8d_pkg::*;

  // Byte class boundaries
  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] LEAD2_LO = 8'hC0;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD5_LO = 8'hF8;
  localparam logic [7:0] LEAD6_LO = 8'hFC;

  // Most results one byte can cause
  localparam int MAX_RUN = 2;

  class utf8_scoreboard;
    logic [2:0]          conts_left;
    logic [CP_WIDTH-1:0] gathered;
    bit                  skip_conts;
    result_t             run_q[$];
    result_t             expected_q[$];
    int                  errors;
    int                  bytes_seen;
    int                  bytes_dropped;
    int                  results_seen;
    int                  replaced_seen;
    int                  texts_ended;

    function new();
      conts_left    = '0;
      gathered      = '0;
      skip_conts    = 1'b0;
      errors        = 0;
      bytes_seen    = 0;
      bytes_dropped = 0;
      results_seen  = 0;
      replaced_seen = 0;
      texts_ended   = 0;
    endfunction

    // Queue one result of the current byte
    function void emit(logic [CP_WIDTH-1:0] value, logic repl);
      result_t r;
      if (run_q.size() >= MAX_RUN) return;
      r.code_point  = value;
      r.replaced    = repl;
      r.last_of_run = 1'b0;
      run_q.push_back(r);
    endfunction

    // Decode a byte with no sequence open
    function void open_lead(logic [7:0] b);
      if (b < CONT_LO) begin
        emit(CP_WIDTH'(b), 1'b0);
      end else if (b < LEAD2_LO) begin
        skip_conts = 1'b1;
        emit(REPLACEMENT_CHAR, 1'b1);
      end else if (b < LEAD3_LO) begin
        gathered   = CP_WIDTH'(b[4:0]);
        conts_left = 3'd1;
      end else if (b < LEAD4_LO) begin
        gathered   = CP_WIDTH'(b[3:0]);
        conts_left = 3'd2;
      end else if (b < LEAD5_LO) begin
        gathered   = CP_WIDTH'(b[2:0]);
        conts_left = 3'd3;
      end else if (b < LEAD6_LO) begin
        gathered   = CP_WIDTH'(b[1:0]);
        conts_left = 3'd4;
      end else begin
        gathered   = CP_WIDTH'(b[0]);
        conts_left = 3'd5;
      end
    endfunction

    // Predict the results of one accepted byte transaction
    function void note_byte(logic [7:0] b, logic eot);
      bit      is_cont;
      result_t r;
      is_cont = (b >= CONT_LO) && (b < LEAD2_LO);
      run_q.delete();
      if (skip_conts && is_cont) begin
        bytes_dropped++;
      end else begin
        skip_conts = 1'b0;
        if (conts_left != 0) begin
          if (is_cont) begin
            gathered   = {gathered[CP_WIDTH-7:0], b[5:0]};
            conts_left = conts_left - 3'd1;
            if (conts_left == 0) begin
              emit(gathered, 1'b0);
              gathered = '0;
            end
          end else begin
            // Interrupted: replace, then decode the byte as a new lead
            emit(REPLACEMENT_CHAR, 1'b1);
            conts_left = '0;
            gathered   = '0;
            open_lead(b);
          end
        end else begin
          open_lead(b);
        end
        if (eot && conts_left != 0) emit(REPLACEMENT_CHAR, 1'b1);
      end
      // End of text: start the next text from a clean state
      if (eot) begin
        conts_left = '0;
        gathered   = '0;
        skip_conts = 1'b0;
        texts_ended++;
      end
      if (run_q.size() > 0) begin
        r = run_q.pop_back();
        r.last_of_run = 1'b1;
        run_q.push_back(r);
      end
      foreach (run_q[i]) expected_q.push_back(run_q[i]);
      bytes_seen++;
    endfunction

    // Compare one accepted result transaction with the oldest expectation
    function void check_result(logic [CP_WIDTH-1:0] cp, logic repl, logic last);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: code_point %h replaced %b last_of_run %b", cp, repl, last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      if (want.replaced) replaced_seen++;
      if (cp !== want.code_point) begin
        $error("code_point: expected %h, actual %h", want.code_point, cp);
        errors++;
      end
      if (repl !== want.replaced) begin
        $error("replaced: expected %b, actual %b", want.replaced, repl);
        errors++;
      end
      if (last !== want.last_of_run) begin
        $error("last_of_run: expected %b, actual %b", want.last_of_run, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int decoded_bytes();
      return bytes_seen - bytes_dropped;
    endfunction
  endclass

endpackage

FILE: bench/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import u8d_pkg::*;
  import utf8_check_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 1500;
  localparam int STALL_CYCLES = 400;

  // Directed bytes: {end_of_text, text_byte}
  localparam logic [8:0] DIRECTED [28] = '{
    9'h000, 9'h07F, 9'h080, 9'h0BF, 9'h0C3, 9'h0A9,
    9'h0E2, 9'h082, 9'h0AC,
    9'h0F8, 9'h088, 9'h080, 9'h080, 9'h080,
    9'h0FF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
    9'h0E2, 9'h041,
    9'h0E2, 9'h0C3, 9'h0A9,
    9'h1F4,
    9'h080, 9'h180
  };

  logic                clk;
  logic                rst;
  logic                byte_valid;
  logic                byte_ready;
  logic [7:0]          text_byte;
  logic                end_of_text;
  logic                result_valid;
  logic                result_ready;
  logic [CP_WIDTH-1:0] code_point;
  logic                replaced;
  logic                last_of_run;

  utf8_scoreboard sb;
  bit             idle_on = 1'b1;
  int             stall_request = 0;
  int             cycle_count = 0;

  utf8_stream_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .text_byte    (text_byte),
    .end_of_text  (end_of_text),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .code_point   (code_point),
    .replaced     (replaced),
    .last_of_run  (last_of_run)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one byte, idling at random first; return once it is accepted
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while (idle_on && $urandom_range(99) < 25) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid  <= 1'b1;
    text_byte   <= b;
    end_of_text <= eot;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    sb.note_byte(b, eot);
  endtask

  // Send a lead for n_cont continuations, followed by n_sent of them
  task automatic send_seq(input int n_cont, input int n_sent, input bit eot_last);
    logic [7:0] lead;
    case (n_cont)
      0:       lead = 8'($urandom_range(127));
      1:       lead = LEAD2_LO | 8'($urandom_range(31));
      2:       lead = LEAD3_LO | 8'($urandom_range(15));
      3:       lead = LEAD4_LO | 8'($urandom_range(7));
      4:       lead = LEAD5_LO | 8'($urandom_range(3));
      default: lead = LEAD6_LO | 8'($urandom_range(3));
    endcase
    send_byte(lead, eot_last && n_sent == 0);
    for (int i = 1; i <= n_sent; i++)
      send_byte(CONT_LO | 8'($urandom_range(63)), eot_last && i == n_sent);
  endtask

  // Mostly well-formed sequences; the rest truncated, stray or raw noise
  task automatic send_unit();
    int kind;
    int n_cont;
    int k;
    kind = $urandom_range(99);
    if (kind < 70) begin
      n_cont = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 5);
      send_seq(n_cont, n_cont, $urandom_range(19) == 0);
    end else if (kind < 80) begin
      n_cont = $urandom_range(1, 5);
      send_seq(n_cont, $urandom_range(0, n_cont - 1), $urandom_range(3) == 0);
    end else if (kind < 90) begin
      k = $urandom_range(1, 4);
      repeat (k) send_byte(CONT_LO | 8'($urandom_range(63)), $urandom_range(15) == 0);
    end else begin
      send_byte(8'($urandom), $urandom_range(7) == 0);
    end
  endtask

  task automatic send_until(input int decoded_target);
    while (sb.decoded_bytes() < decoded_target) send_unit();
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: check each transaction, then pick ready for the next cycle
  initial begin
    int hold_left;
    hold_left = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready)
        sb.check_result(code_point, replaced, last_of_run);
      if (stall_request != 0) begin
        hold_left = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (idle_on && $urandom_range(99) < 25) begin
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Byte side: reset, directed bytes, then random phases
  initial begin
    sb = new();
    rst         <= 1'b1;
    byte_valid  <= 1'b0;
    text_byte   <= '0;
    end_of_text <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIRECTED); i++)
      send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

    send_until(sb.decoded_bytes() + 500);

    // Run flat out on both sides
    idle_on = 1'b0;
    send_until(sb.decoded_bytes() + 300);
    idle_on = 1'b1;

    // Hold off the receiver while bytes keep coming
    stall_request = STALL_CYCLES;
    send_until(sb.decoded_bytes() + 150);

    // Pause the sender until every result is out
    wait_drained();
    send_until(RANDOM_BYTES + $size(DIRECTED));
    byte_valid <= 1'b0;

    wait_drained();
    repeat (4) @(posedge clk);

    $display("Checked %0d results (%0d replaced) from %0d bytes, %0d dropped in skip mode,",
             sb.results_seen, sb.replaced_seen, sb.bytes_seen, sb.bytes_dropped);
    $display("over %0d texts, with a long receiver stall and a full drain pause.",
             sb.texts_ended);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/u8d_pkg.sv
rtl/core/utf8_stream_decoder.sv
bench/utf8_check_pkg.sv
bench/testbench.sv
